// ===== hw/rtl/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types, codes and constants of the microinstruction datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

	// default word memory depth
	localparam int MEM_WORDS_DEF = 16;

	// memory contents after reset: all zero except one word
	localparam int          MEM_INIT_ADDR = 4;
	localparam logic [31:0] MEM_INIT_VAL  = 32'h0000_0002;

	// MBR sign extension
	localparam logic [7:0]  MBR_SIGN_BIT = 8'h80;
	localparam logic [31:0] MBR_EXT_MASK = 32'hFFFF_FF00;

	// request kinds
	localparam logic [2:0] KIND_EXEC     = 3'd0;
	localparam logic [2:0] KIND_WR_REG   = 3'd1;
	localparam logic [2:0] KIND_WR_MEM   = 3'd2;
	localparam logic [2:0] KIND_RD_REG   = 3'd3;
	localparam logic [2:0] KIND_RD_MEM   = 3'd4;

	// memory operations of a microinstruction
	localparam logic [1:0] MOP_NONE  = 2'd0;
	localparam logic [1:0] MOP_READ  = 2'd1;
	localparam logic [1:0] MOP_WRITE = 2'd2;
	localparam logic [1:0] MOP_FETCH = 2'd3;

	// memory status codes
	localparam logic [1:0] MST_NONE = 2'd0;
	localparam logic [1:0] MST_DONE = 2'd1;
	localparam logic [1:0] MST_OOR  = 2'd2;

	// B bus sources
	localparam logic [3:0] BSEL_MDR  = 4'd0;
	localparam logic [3:0] BSEL_PC   = 4'd1;
	localparam logic [3:0] BSEL_MBRS = 4'd2;
	localparam logic [3:0] BSEL_MBRU = 4'd3;
	localparam logic [3:0] BSEL_SP   = 4'd4;
	localparam logic [3:0] BSEL_LV   = 4'd5;
	localparam logic [3:0] BSEL_CPP  = 4'd6;
	localparam logic [3:0] BSEL_TOS  = 4'd7;
	localparam logic [3:0] BSEL_OPC  = 4'd8;

	// register indexes used by the preload and readback requests
	localparam logic [3:0] REG_H   = 4'd0;
	localparam logic [3:0] REG_OPC = 4'd1;
	localparam logic [3:0] REG_TOS = 4'd2;
	localparam logic [3:0] REG_CPP = 4'd3;
	localparam logic [3:0] REG_LV  = 4'd4;
	localparam logic [3:0] REG_SP  = 4'd5;
	localparam logic [3:0] REG_PC  = 4'd6;
	localparam logic [3:0] REG_MDR = 4'd7;
	localparam logic [3:0] REG_MAR = 4'd8;
	localparam logic [3:0] REG_MBR = 4'd9;

	// ALU control bit positions
	localparam int ALU_SLL8 = 7;
	localparam int ALU_SRA1 = 6;
	localparam int ALU_F0   = 5;
	localparam int ALU_F1   = 4;
	localparam int ALU_ENA  = 3;
	localparam int ALU_ENB  = 2;
	localparam int ALU_INVA = 1;
	localparam int ALU_INC  = 0;

	// C bus select bit positions
	localparam int CS_H   = 8;
	localparam int CS_OPC = 7;
	localparam int CS_TOS = 6;
	localparam int CS_CPP = 5;
	localparam int CS_LV  = 4;
	localparam int CS_SP  = 3;
	localparam int CS_PC  = 2;
	localparam int CS_MDR = 1;
	localparam int CS_MAR = 0;

	typedef struct packed {
		logic [31:0] result;
		logic        carry;
	} alu_out_t;

	typedef struct packed {
		logic        we;
		logic        re;
		logic [31:0] wdata;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smd_alu.sv =====
// ----------------------------------------------------------------------------
// smd_alu
// Mic-1 style ALU with gating, inversion, increment and the output shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_alu
	import smd_pkg::*;
(
	input  wire logic [7:0]  ctl,
	input  wire logic [31:0] h,
	input  wire logic [31:0] b_bus,
	output alu_out_t         out
);

	logic [31:0] a_op;
	logic [31:0] b_op;
	logic [32:0] sum;
	logic [31:0] alu_val;
	logic        sll;
	logic        sra;

	always_comb begin
		a_op = ctl[ALU_ENA] ? h : 32'd0;
		if (ctl[ALU_INVA]) begin
			a_op = ~a_op;
		end
		b_op = ctl[ALU_ENB] ? b_bus : 32'd0;
		sum  = {1'b0, a_op} + {1'b0, b_op} + {32'd0, ctl[ALU_INC]};
		sll  = ctl[ALU_SLL8];
		sra  = ctl[ALU_SRA1];

		// only the F0 F1 combination adds, everything else passes A
		if (ctl[ALU_F0] && ctl[ALU_F1]) begin
			alu_val   = sum[31:0];
			out.carry = sum[32];
		end else begin
			alu_val   = a_op;
			out.carry = 1'b0;
		end

		if (sll && !sra) begin
			out.result = {alu_val[23:0], 8'd0};
		end else if (sra && !sll) begin
			out.result = {alu_val[31], alu_val[31:1]};
		end else begin
			out.result = alu_val;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/smd_mem.sv =====
// ----------------------------------------------------------------------------
// smd_mem
// Word memory with one write and one registered read port, and a clearing
// pass after reset that loads the power-on contents.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_mem
	import smd_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	parameter int ADDR_W    = $clog2(MEM_WORDS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mem_req_t          req,
	input  wire logic [ADDR_W-1:0] addr,
	output logic [31:0]            rdata,
	output logic                   busy
);

	logic [31:0]       mem [MEM_WORDS];
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              busy_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       wr_data;

	assign busy = busy_q;

	always_comb begin
		if (busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = (clr_cnt_q == ADDR_W'(MEM_INIT_ADDR)) ? MEM_INIT_VAL : 32'd0;
		end else begin
			wr_en   = req.we;
			wr_addr = addr;
			wr_data = req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(MEM_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds until the next read
		if (req.re && !busy_q) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/stack_machine_microinstruction_datapath.sv =====
// ----------------------------------------------------------------------------
// stack_machine_microinstruction_datapath
// Mic-1 style datapath executing one microinstruction per request.
// ----------------------------------------------------------------------------
// One request is taken per clock unless m_tready stalls the output or the
// memory is busy. A request is latched in an input register, then runs through
// B bus select, ALU, shifter and C bus write once the output register is free,
// and its result is loaded into the output register at the end of that cycle,
// which raises m_tvalid. The cycle is set by the 32-bit add followed by the
// shifter and the C bus into the nine registers.
// A memory read lands in MDR late through the registered read
// port and is forwarded to the next request meanwhile. After reset the word
// memory runs a clearing pass over all MEM_WORDS words, during which s_tready
// stays low.
`default_nettype none

module stack_machine_microinstruction_datapath
	import smd_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// alu_control[7:0], c_select[16:8], mem_op[18:17], b_select[22:19],
	// target[26:23], load_value[58:27], zero fill [63:59]
	input  wire logic [63:0] s_tdata,
	// kind[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// alu_result[31:0], carry_out[32], negative[33], zero[34],
	// memory_status[36:35], read_value[68:37], zero fill [71:69]
	output logic [71:0]      m_tdata
);

	localparam int ADDR_W = $clog2(MEM_WORDS);

	// input register
	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [7:0]  ctl_s1;
	logic [8:0]  csel_s1;
	logic [1:0]  mop_s1;
	logic [3:0]  bsel_s1;
	logic [3:0]  tgt_s1;
	logic [31:0] val_s1;

	// datapath registers
	logic [31:0] h_q, opc_q, tos_q, cpp_q, lv_q, sp_q, pc_q, mdr_q, mar_q;
	logic [7:0]  mbr_q;
	logic        mdr_pend_q;

	// output register
	logic [31:0] out_res_q;
	logic        out_carry_q;
	logic        out_neg_q;
	logic        out_zero_q;
	logic [1:0]  out_mst_q;
	logic [31:0] out_rd_q;
	logic        out_rdmem_q;

	logic              exec;
	logic              is_exec;
	logic              mem_busy;
	logic [31:0]       mem_rdata;
	logic [31:0]       mdr_eff;
	logic [31:0]       mbr_zx;
	logic [31:0]       mbr_sx;
	logic [31:0]       b_bus;
	alu_out_t          alu_out;
	logic [31:0]       mar_new;
	logic [31:0]       mdr_new;
	logic [31:0]       addr32;
	logic              addr_ok;
	logic              mem_rd_op;
	logic              mem_wr_op;
	mem_req_t          mem_req;
	logic [8:0]        wen;
	logic [31:0]       wdat;
	logic              fetch;
	logic [1:0]        mst;
	logic [31:0]       rd_reg;
	logic              mdr_pend_d;

	assign exec     = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !mem_busy && (!valid_s1 || exec);
	assign is_exec  = (kind_s1 == KIND_EXEC);
	assign fetch    = is_exec && (mop_s1 == MOP_FETCH);

	// MDR value from a read issued by the previous request
	assign mdr_eff = mdr_pend_q ? mem_rdata : mdr_q;
	assign mbr_zx  = {24'd0, mbr_q};
	assign mbr_sx  = ((mbr_q & MBR_SIGN_BIT) != 8'd0) ? (MBR_EXT_MASK | mbr_zx) : mbr_zx;

	always_comb begin
		case (bsel_s1)
			BSEL_MDR:  b_bus = mdr_eff;
			BSEL_PC:   b_bus = pc_q;
			BSEL_MBRS: b_bus = mbr_sx;
			BSEL_MBRU: b_bus = mbr_zx;
			BSEL_SP:   b_bus = sp_q;
			BSEL_LV:   b_bus = lv_q;
			BSEL_CPP:  b_bus = cpp_q;
			BSEL_TOS:  b_bus = tos_q;
			BSEL_OPC:  b_bus = opc_q;
			default:   b_bus = 32'd0;
		endcase
	end

	smd_alu u_alu (
		.ctl   (ctl_s1),
		.h     (h_q),
		.b_bus (b_bus),
		.out   (alu_out)
	);

	// memory side sees MAR and MDR after the C bus write
	assign mar_new = csel_s1[CS_MAR] ? alu_out.result : mar_q;
	assign mdr_new = csel_s1[CS_MDR] ? alu_out.result : mdr_eff;
	assign addr32  = is_exec ? mar_new : {28'd0, tgt_s1};
	assign addr_ok = addr32 < 32'(MEM_WORDS);

	always_comb begin
		mem_rd_op = 1'b0;
		mem_wr_op = 1'b0;
		case (kind_s1)
			KIND_EXEC: begin
				mem_rd_op = (mop_s1 == MOP_READ);
				mem_wr_op = (mop_s1 == MOP_WRITE);
			end
			KIND_WR_MEM: mem_wr_op = 1'b1;
			KIND_RD_MEM: mem_rd_op = 1'b1;
			default: begin
				mem_rd_op = 1'b0;
				mem_wr_op = 1'b0;
			end
		endcase
	end

	assign mem_req.we    = exec && mem_wr_op && addr_ok;
	assign mem_req.re    = exec && mem_rd_op && addr_ok;
	assign mem_req.wdata = is_exec ? mdr_new : val_s1;

	smd_mem #(
		.MEM_WORDS (MEM_WORDS),
		.ADDR_W    (ADDR_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.addr   (addr32[ADDR_W-1:0]),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	// register write enables, indexed H..MAR
	always_comb begin
		wen  = 9'd0;
		wdat = is_exec ? alu_out.result : val_s1;
		if (exec && is_exec) begin
			wen[REG_H]   = csel_s1[CS_H] || fetch;
			wen[REG_OPC] = csel_s1[CS_OPC];
			wen[REG_TOS] = csel_s1[CS_TOS];
			wen[REG_CPP] = csel_s1[CS_CPP];
			wen[REG_LV]  = csel_s1[CS_LV];
			wen[REG_SP]  = csel_s1[CS_SP];
			wen[REG_PC]  = csel_s1[CS_PC];
			wen[REG_MDR] = csel_s1[CS_MDR];
			wen[REG_MAR] = csel_s1[CS_MAR];
		end else if (exec && (kind_s1 == KIND_WR_REG)) begin
			wen[REG_H]   = (tgt_s1 == REG_H);
			wen[REG_OPC] = (tgt_s1 == REG_OPC);
			wen[REG_TOS] = (tgt_s1 == REG_TOS);
			wen[REG_CPP] = (tgt_s1 == REG_CPP);
			wen[REG_LV]  = (tgt_s1 == REG_LV);
			wen[REG_SP]  = (tgt_s1 == REG_SP);
			wen[REG_PC]  = (tgt_s1 == REG_PC);
			wen[REG_MDR] = (tgt_s1 == REG_MDR);
			wen[REG_MAR] = (tgt_s1 == REG_MAR);
		end
	end

	assign mdr_pend_d = exec && is_exec && (mop_s1 == MOP_READ) && addr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q        <= '0;
			opc_q      <= '0;
			tos_q      <= '0;
			cpp_q      <= '0;
			lv_q       <= '0;
			sp_q       <= '0;
			pc_q       <= '0;
			mdr_q      <= '0;
			mar_q      <= '0;
			mbr_q      <= '0;
			mdr_pend_q <= 1'b0;
		end else begin
			if (wen[REG_H]) begin
				h_q <= fetch ? mbr_zx : wdat;
			end
			if (wen[REG_OPC]) opc_q <= wdat;
			if (wen[REG_TOS]) tos_q <= wdat;
			if (wen[REG_CPP]) cpp_q <= wdat;
			if (wen[REG_LV])  lv_q  <= wdat;
			if (wen[REG_SP])  sp_q  <= wdat;
			if (wen[REG_PC])  pc_q  <= wdat;
			if (wen[REG_MAR]) mar_q <= wdat;
			// a newer write to MDR wins over the late read data
			if (wen[REG_MDR]) begin
				mdr_q <= wdat;
			end else if (mdr_pend_q) begin
				mdr_q <= mem_rdata;
			end
			if (exec && (kind_s1 == KIND_WR_REG) && (tgt_s1 == REG_MBR)) begin
				mbr_q <= val_s1[7:0];
			end
			mdr_pend_q <= mdr_pend_d;
		end
	end

	// register readback
	always_comb begin
		case (tgt_s1)
			REG_H:   rd_reg = h_q;
			REG_OPC: rd_reg = opc_q;
			REG_TOS: rd_reg = tos_q;
			REG_CPP: rd_reg = cpp_q;
			REG_LV:  rd_reg = lv_q;
			REG_SP:  rd_reg = sp_q;
			REG_PC:  rd_reg = pc_q;
			REG_MDR: rd_reg = mdr_eff;
			REG_MAR: rd_reg = mar_q;
			REG_MBR: rd_reg = mbr_zx;
			default: rd_reg = 32'd0;
		endcase
	end

	always_comb begin
		case (kind_s1)
			KIND_EXEC: begin
				if (mop_s1 == MOP_FETCH) begin
					mst = MST_DONE;
				end else if (mop_s1 == MOP_NONE) begin
					mst = MST_NONE;
				end else begin
					mst = addr_ok ? MST_DONE : MST_OOR;
				end
			end
			KIND_WR_MEM, KIND_RD_MEM: mst = addr_ok ? MST_DONE : MST_OOR;
			default: mst = MST_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			ctl_s1  <= s_tdata[7:0];
			csel_s1 <= s_tdata[16:8];
			mop_s1  <= s_tdata[18:17];
			bsel_s1 <= s_tdata[22:19];
			tgt_s1  <= s_tdata[26:23];
			val_s1  <= s_tdata[58:27];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (exec) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_res_q   <= is_exec ? alu_out.result : 32'd0;
			out_carry_q <= is_exec && alu_out.carry;
			out_neg_q   <= is_exec && alu_out.result[31];
			out_zero_q  <= is_exec && (alu_out.result == 32'd0);
			out_mst_q   <= mst;
			out_rd_q    <= (kind_s1 == KIND_RD_REG) ? rd_reg : 32'd0;
			out_rdmem_q <= (kind_s1 == KIND_RD_MEM) && addr_ok;
		end
	end

	// memory read data holds while the result waits, since no request runs
	assign m_tdata = {3'd0, out_rdmem_q ? mem_rdata : out_rd_q, out_mst_q,
		out_zero_q, out_neg_q, out_carry_q, out_res_q};

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !s_tready)
		else $error("request accepted during memory clearing pass");

	a_mdr_pend_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		mdr_pend_q |-> $past(exec && is_exec && (mop_s1 == MOP_READ)))
		else $error("MDR forward pending without a memory read");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(exec))
		else $error("result appeared without an executed request");

endmodule

`default_nettype wire
